FILE: rtl/bve_pkg.sv
`timescale 1ns / 1ps
// Package: shared widths, constants, register indexes and controller types.
package bve_pkg;

  localparam int FIELD_WIDTH       = 32;
  localparam int POS_WIDTH_DEFAULT = 32;
  localparam int POLE_WIDTH        = 16;
  localparam int DT_WIDTH          = 16;
  localparam int APB_DATA_WIDTH    = 32;
  localparam int APB_ADDR_WIDTH    = 3;

  // Constant 2 in Q8.16.
  localparam int TWO_Q16 = 131072;
  // 2 * 256: feed-forward scale from Q8.8 pole times Q15.16 delta to Q.32.
  localparam int FF_SHIFT = 9;

  localparam logic [POLE_WIDTH-1:0] POLE_RESET = 16'd2560;

  typedef enum logic [0:0] {
    REG_X_POLE = 1'b0,
    REG_Y_POLE = 1'b1
  } reg_idx_t;

  // Datapath command issued by the controller each cycle.
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_MUL_KDT,
    STEP_MUL_FF,
    STEP_MUL_FB,
    STEP_NUM,
    STEP_DIV,
    STEP_COMMIT
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_KDT,
    ST_MUL_FF,
    ST_MUL_FB,
    ST_NUM,
    ST_DIV,
    ST_COMMIT
  } state_t;

endpackage

FILE: rtl/bve_sample_if.sv
`timescale 1ns / 1ps
// Interface: position sample channel (valid/ready plus sample payload).
interface bve_sample_if;
  import bve_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] pos_x;
  logic [FIELD_WIDTH-1:0] pos_y;
  logic [DT_WIDTH-1:0]    sample_interval;
  logic [FIELD_WIDTH-1:0] vz_in;

  modport source (output valid, pos_x, pos_y, sample_interval, vz_in, input ready);
  modport sink   (input valid, pos_x, pos_y, sample_interval, vz_in, output ready);
endinterface

FILE: rtl/bve_estimate_if.sv
`timescale 1ns / 1ps
// Interface: velocity estimate channel (valid/ready plus velocity payload).
interface bve_estimate_if;
  import bve_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] vel_x;
  logic [FIELD_WIDTH-1:0] vel_y;
  logic [FIELD_WIDTH-1:0] vel_z;

  modport source (output valid, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, output ready);
endinterface

FILE: rtl/bve_axis.sv
`timescale 1ns / 1ps
// Module: one axis datapath (multiplier, numerator, restoring divider, saturation).
module bve_axis #(
  parameter int POS_WIDTH = bve_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bve_pkg::step_t                  step,
  input  logic [bve_pkg::POLE_WIDTH-1:0]  pole,
  input  logic [bve_pkg::DT_WIDTH-1:0]    dt,
  input  logic [bve_pkg::FIELD_WIDTH-1:0] pos_raw,
  output logic [bve_pkg::FIELD_WIDTH-1:0] vel
);
  import bve_pkg::*;

  localparam int PW     = (POS_WIDTH > FIELD_WIDTH) ? FIELD_WIDTH : POS_WIDTH;
  localparam int KDT_W  = 24;
  localparam int A_W    = KDT_W + 1;
  localparam int B_W    = PW + 1;
  localparam int PROD_W = A_W + B_W;
  localparam int NUM_W  = PW + 27;
  localparam int MAG_W  = PW + 26;
  localparam int Q_BITS = PW + 9;
  localparam int DEN_W  = KDT_W + 1;

  localparam logic signed [A_W-1:0] TWO_A   = A_W'(TWO_Q16);
  localparam logic [DEN_W-1:0]      TWO_DEN = DEN_W'(TWO_Q16);
  localparam logic [Q_BITS-1:0] MAG_POS_MAX = {{(Q_BITS-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic [Q_BITS-1:0] MAG_NEG_MAX =
    {{(Q_BITS-PW){1'b0}}, 1'b1, {(PW-1){1'b0}}};

  logic signed [PW-1:0]     prev_pos;
  logic signed [PW-1:0]     prev_vel;
  logic signed [PW:0]       dpos;
  logic [DT_WIDTH-1:0]      dt_q;
  logic signed [PROD_W-1:0] prod;
  logic [KDT_W-1:0]         kdt;
  logic signed [NUM_W-1:0]  ff;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         rem;
  logic [Q_BITS-1:0]        quo;
  logic                     neg;

  logic signed [PW-1:0]    pos;
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        num_abs;
  logic [MAG_W-1:0]        mag;
  logic [DEN_W:0]          shifted;
  logic [DEN_W+1:0]        diff;
  logic                    fits;
  logic signed [PW-1:0]    sat;

  assign pos = pos_raw[PW-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      STEP_MUL_KDT: begin
        mul_a = A_W'($signed({1'b0, pole}));
        mul_b = B_W'($signed({1'b0, dt_q}));
      end
      STEP_MUL_FF: begin
        mul_a = A_W'($signed({1'b0, pole}));
        mul_b = dpos;
      end
      STEP_MUL_FB: begin
        mul_a = $signed({1'b0, kdt}) - TWO_A;
        mul_b = B_W'(prev_vel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Numerator in Q.32: feed-forward minus feedback.
  assign num     = ff - NUM_W'(prod);
  assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign mag     = num_abs[MAG_W-1:0];

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign shifted = {rem, quo[Q_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign fits    = !diff[DEN_W+1];

  always_comb begin
    if (!neg) begin
      sat = (quo > MAG_POS_MAX) ? {1'b0, {(PW-1){1'b1}}} : quo[PW-1:0];
    end else begin
      sat = (quo > MAG_NEG_MAX) ? {1'b1, {(PW-1){1'b0}}} : -quo[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pos <= '0;
      prev_vel <= '0;
    end else begin
      case (step)
        STEP_LOAD:   prev_pos <= pos;
        STEP_COMMIT: prev_vel <= sat;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      STEP_LOAD: begin
        dpos <= (PW+1)'(pos) - (PW+1)'(prev_pos);
        dt_q <= dt;
      end
      STEP_MUL_KDT: prod <= mul_a * mul_b;
      STEP_MUL_FF: begin
        kdt  <= prod[KDT_W+7:8];
        prod <= mul_a * mul_b;
      end
      STEP_MUL_FB: begin
        ff   <= NUM_W'(prod) <<< FF_SHIFT;
        prod <= mul_a * mul_b;
      end
      STEP_NUM: begin
        neg <= num[NUM_W-1];
        rem <= DEN_W'(mag[MAG_W-1:Q_BITS]);
        quo <= mag[Q_BITS-1:0];
        den <= {1'b0, kdt} + TWO_DEN;
      end
      STEP_DIV: begin
        rem <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo <= {quo[Q_BITS-2:0], fits};
      end
      default: begin
      end
    endcase
  end

  assign vel = FIELD_WIDTH'(prev_vel);

endmodule

FILE: rtl/bve_ctrl.sv
`timescale 1ns / 1ps
// Module: controller state machine that sequences both axis datapaths.
module bve_ctrl #(
  parameter int POS_WIDTH = bve_pkg::POS_WIDTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           sample_valid,
  output logic           sample_ready,
  output logic           estimate_valid,
  input  logic           estimate_ready,
  output bve_pkg::step_t step
);
  import bve_pkg::*;

  localparam int PW     = (POS_WIDTH > FIELD_WIDTH) ? FIELD_WIDTH : POS_WIDTH;
  localparam int Q_BITS = PW + 9;
  localparam int CNT_W  = $clog2(Q_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_BITS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;
  logic             out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_cnt  <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      div_cnt  <= div_cnt_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    state_next    = state;
    div_cnt_next  = div_cnt;
    out_full_next = out_full && !estimate_ready;
    step          = STEP_NONE;
    sample_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          step       = STEP_LOAD;
          state_next = ST_MUL_KDT;
        end
      end
      ST_MUL_KDT: begin
        step       = STEP_MUL_KDT;
        state_next = ST_MUL_FF;
      end
      ST_MUL_FF: begin
        step       = STEP_MUL_FF;
        state_next = ST_MUL_FB;
      end
      ST_MUL_FB: begin
        step       = STEP_MUL_FB;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        step         = STEP_NUM;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        step = STEP_DIV;
        if (div_cnt == CNT_LAST) begin
          state_next = ST_COMMIT;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      ST_COMMIT: begin
        // Hold until the output register is free.
        if (!out_full || estimate_ready) begin
          step          = STEP_COMMIT;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign estimate_valid = out_full;

endmodule

FILE: rtl/bilinear_velocity_estimator.sv
`timescale 1ns / 1ps
// Top level: bilinear filtered-derivative velocity estimator with APB poles.
//
//   channel    dir   handshake        words
//   sample     in    valid / ready    pos_x, pos_y, sample_interval, vz_in
//   estimate   out   valid / ready    vel_x, vel_y, vel_z
//   apb        in    psel / penable   x_velocity_pole (0x0), y_velocity_pole (0x4)
//
// One sample word is taken at a time. The position width is POS_WIDTH, capped
// at the 32-bit field. After an accept, each axis steps three times through its
// multiplier, forms the numerator, runs the restoring divider, which retires one
// quotient bit per cycle, and commits the result into the output register; the
// next sample can be taken as soon as that result word is valid.
// Reset is synchronous and active high; it clears the previous positions and
// velocities and loads both poles with 10 rad/s. The result sits in an output
// register, so a new sample is accepted while the previous result waits; a
// finished result is held in its last step until that register is free.
module bilinear_velocity_estimator #(
  parameter int POS_WIDTH = bve_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bve_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [bve_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [bve_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready,
  bve_sample_if.sink                         sample,
  bve_estimate_if.source                     estimate
);
  import bve_pkg::*;

  logic [POLE_WIDTH-1:0]  x_pole;
  logic [POLE_WIDTH-1:0]  y_pole;
  logic [FIELD_WIDTH-1:0] vz_hold;
  logic [FIELD_WIDTH-1:0] vel_z;
  reg_idx_t               reg_idx;
  logic                   cfg_write;
  step_t                  step;

  // Registers are word aligned; the low two address bits are ignored.
  assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_WIDTH-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pole <= POLE_RESET;
      y_pole <= POLE_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_X_POLE: x_pole <= pwdata[POLE_WIDTH-1:0];
        REG_Y_POLE: y_pole <= pwdata[POLE_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_POLE: prdata = APB_DATA_WIDTH'(x_pole);
      REG_Y_POLE: prdata = APB_DATA_WIDTH'(y_pole);
      default:    prdata = '0;
    endcase
  end

  // Capture vz at accept, move it to the output only when the result commits,
  // so a waiting result keeps its own vz.
  always_ff @(posedge clk) begin
    if (step == STEP_LOAD) begin
      vz_hold <= sample.vz_in;
    end
    if (step == STEP_COMMIT) begin
      vel_z <= vz_hold;
    end
  end

  bve_ctrl #(
    .POS_WIDTH (POS_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample.valid),
    .sample_ready   (sample.ready),
    .estimate_valid (estimate.valid),
    .estimate_ready (estimate.ready),
    .step           (step)
  );

  bve_axis #(
    .POS_WIDTH (POS_WIDTH)
  ) u_axis_x (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pole    (x_pole),
    .dt      (sample.sample_interval),
    .pos_raw (sample.pos_x),
    .vel     (estimate.vel_x)
  );

  bve_axis #(
    .POS_WIDTH (POS_WIDTH)
  ) u_axis_y (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pole    (y_pole),
    .dt      (sample.sample_interval),
    .pos_raw (sample.pos_y),
    .vel     (estimate.vel_y)
  );

  assign estimate.vel_z = vel_z;

`ifndef SYNTHESIS
  // Only one sample is in flight: ready drops right after an accept.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample accepted while another is in flight");

  // A commit never overwrites a result that has not been taken.
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    step == STEP_COMMIT |-> (!estimate.valid || estimate.ready))
    else $error("commit over a pending result");

  // Every commit presents a result on the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    step == STEP_COMMIT |=> estimate.valid)
    else $error("commit without a valid result");
`endif

endmodule

FILE: tb/bilinear_velocity_estimator_tb.sv
`timescale 1ns / 1ps
// Testbench: drives sample words and pole writes, predicts and checks every estimate word.
module bilinear_velocity_estimator_tb;
  import bve_pkg::*;

  localparam int POS_WIDTH   = POS_WIDTH_DEFAULT;
  // Positions wider than the field act as the field width.
  localparam int PW          = (POS_WIDTH > FIELD_WIDTH) ? FIELD_WIDTH : POS_WIDTH;
  localparam longint VEL_MAX = (longint'(1) <<< (PW - 1)) - 1;
  localparam longint VEL_MIN = -VEL_MAX - 1;

  localparam int DIRECTED_ROWS = 17;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 106;
  localparam int TIMEOUT_NS    = 10_000_000;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] pos_x;
    logic [FIELD_WIDTH-1:0] pos_y;
    logic [DT_WIDTH-1:0]    dt;
    logic [FIELD_WIDTH-1:0] vz;
  } sample_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] vel_x;
    logic [FIELD_WIDTH-1:0] vel_y;
    logic [FIELD_WIDTH-1:0] vel_z;
  } estimate_t;

  // One directed step: the poles it runs under, the sample word, and, where the
  // answer is plain from the filter equation, the velocities typed in by hand.
  typedef struct packed {
    logic [POLE_WIDTH-1:0]  x_pole;
    logic [POLE_WIDTH-1:0]  y_pole;
    logic [FIELD_WIDTH-1:0] pos_x;
    logic [FIELD_WIDTH-1:0] pos_y;
    logic [DT_WIDTH-1:0]    dt;
    logic [FIELD_WIDTH-1:0] vz;
    bit                     known;
    logic [FIELD_WIDTH-1:0] want_x;
    logic [FIELD_WIDTH-1:0] want_y;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  bve_sample_if   sample_ch ();
  bve_estimate_if estimate_ch ();

  bilinear_velocity_estimator #(
    .POS_WIDTH (POS_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample   (sample_ch),
    .estimate (estimate_ch)
  );

  always #10 clk = ~clk;

  // Filter state as the block should hold it: poles, last position and last
  // (saturated) velocity per axis, index 0 for x and 1 for y.
  logic [POLE_WIDTH-1:0] pole_q [2]   = '{POLE_RESET, POLE_RESET};
  longint                last_pos [2] = '{0, 0};
  longint                last_vel [2] = '{0, 0};

  estimate_t pending_estimates [$];

  int  fail_count     = 0;
  int  samples_sent   = 0;
  int  estimates_seen = 0;
  int  pole_writes    = 0;
  bit  steady         = 1'b0;
  int  stall_left     = 0;

  logic [FIELD_WIDTH-1:0] extreme_pos [4] = '{32'h7FFF_FFFF, 32'h8000_0000,
                                              32'h0000_0000, 32'hFFFF_FFFF};
  logic [DT_WIDTH-1:0]    extreme_dt [4]  = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};

  // Directed steps. Typed rows: after reset nothing has moved, so the first
  // estimate is zero; a maximal pole with a zero interval drives a full-scale
  // jump into saturation; a pole of 1.0 with a zero interval gives old velocity
  // plus the raw position step; a zero pole just holds the old velocity.
  step_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'd2560, 16'd2560, 32'h0000_0000, 32'h0000_0000, 16'h0CCD, 32'h7FFF_FFFF,
      1'b1, 32'h0000_0000, 32'h0000_0000},
    '{16'd2560, 16'd2560, 32'h0001_0000, 32'hFFFF_0000, 16'h0CCD, 32'h8000_0000,
      1'b0, 32'h0, 32'h0},
    '{16'd2560, 16'd2560, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 32'h0000_0000,
      1'b0, 32'h0, 32'h0},
    '{16'd2560, 16'd2560, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0001, 32'hFFFF_FFFF,
      1'b0, 32'h0, 32'h0},
    '{16'd2560, 16'd2560, 32'h1234_5678, 32'hEDCB_A987, 16'h0000, 32'h0000_0001,
      1'b0, 32'h0, 32'h0},
    '{16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 32'hA5A5_A5A5,
      1'b1, 32'h8000_0000, 32'h7FFF_FFFF},
    '{16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 32'h5A5A_5A5A,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    '{16'h0100, 16'h0100, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 32'h0000_FFFF,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000},
    '{16'h0100, 16'h0100, 32'h7FFF_FFFE, 32'h8000_0001, 16'h0000, 32'hFFFF_0000,
      1'b1, 32'h7FFF_FFFE, 32'h8000_0001},
    '{16'h0000, 16'h0000, 32'h0000_0000, 32'h4000_0000, 16'hFFFF, 32'h1357_9BDF,
      1'b1, 32'h7FFF_FFFE, 32'h8000_0001},
    '{16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0000_0001, 16'h8000, 32'h2468_ACE0,
      1'b1, 32'h7FFF_FFFE, 32'h8000_0001},
    '{16'h0100, 16'h0100, 32'h0001_0000, 32'h0000_0001, 16'h0000, 32'hDEAD_BEEF,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0001},
    '{16'h0000, 16'hFFFF, 32'h0002_0000, 32'h0002_0000, 16'h0100, 32'h0F0F_0F0F,
      1'b0, 32'h0, 32'h0},
    '{16'hFFFF, 16'h0000, 32'hFFFE_0000, 32'hFFFE_0000, 16'h4000, 32'hF0F0_F0F0,
      1'b0, 32'h0, 32'h0},
    '{16'h8000, 16'h0001, 32'h5555_5555, 32'hAAAA_AAAA, 16'hFFFF, 32'h3333_3333,
      1'b0, 32'h0, 32'h0},
    '{16'h0001, 16'h8000, 32'hAAAA_AAAA, 32'h5555_5555, 16'h0001, 32'hCCCC_CCCC,
      1'b0, 32'h0, 32'h0},
    '{16'd2560, 16'd2560, 32'h0001_0000, 32'h0001_0000, 16'h0CCD, 32'h5A5A_5A5A,
      1'b0, 32'h0, 32'h0}
  };

  // Advance one axis of the filter:
  //   v = (2*p*dpos*2^8 - (kdt - 2)*v_old) / (kdt + 2), kdt = floor(p*dt) in Q8.16,
  // truncated toward zero, then clamped to the velocity range.
  function automatic logic [FIELD_WIDTH-1:0] filter_axis(input int axis,
                                                         input logic [FIELD_WIDTH-1:0] pos,
                                                         input logic [DT_WIDTH-1:0] dt);
    longint new_pos;
    longint kdt;
    longint num;
    longint vel;
    // Take the low PW bits of the sample, sign-extended.
    new_pos = longint'($signed(pos << (FIELD_WIDTH - PW))) >>> (FIELD_WIDTH - PW);
    kdt = longint'((64'(pole_q[axis]) * 64'(dt)) >> 8);
    num = 512 * longint'(pole_q[axis]) * (new_pos - last_pos[axis])
        - (kdt - TWO_Q16) * last_vel[axis];
    vel = num / (kdt + TWO_Q16);
    if (vel > VEL_MAX) vel = VEL_MAX;
    if (vel < VEL_MIN) vel = VEL_MIN;
    last_pos[axis] = new_pos;
    last_vel[axis] = vel;
    return FIELD_WIDTH'(vel);
  endfunction

  // Present one sample word, hold it until taken, then log what it must produce.
  // Valid stays high from word to word unless a gap is inserted.
  task automatic send_sample(input sample_t s, input bit known,
                             input logic [FIELD_WIDTH-1:0] want_x,
                             input logic [FIELD_WIDTH-1:0] want_y);
    estimate_t e;
    if (!steady && $urandom_range(0, 2) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_ch.valid           <= 1'b1;
    sample_ch.pos_x           <= s.pos_x;
    sample_ch.pos_y           <= s.pos_y;
    sample_ch.sample_interval <= s.dt;
    sample_ch.vz_in           <= s.vz;
    do @(posedge clk); while (!sample_ch.ready);
    e.vel_x = filter_axis(0, s.pos_x, s.dt);
    e.vel_y = filter_axis(1, s.pos_y, s.dt);
    e.vel_z = s.vz;
    if (known) begin
      e.vel_x = want_x;
      e.vel_y = want_y;
    end
    pending_estimates.push_back(e);
    samples_sent++;
  endtask

  // Drop valid and hold off until every logged estimate has come back.
  task automatic drain;
    sample_ch.valid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  // Write both pole registers back to back; psel stays up between the two
  // transfers and drops once at the end. Upper data bits carry noise, which
  // the register must ignore.
  task automatic set_poles(input logic [POLE_WIDTH-1:0] x_pole,
                           input logic [POLE_WIDTH-1:0] y_pole);
    logic [POLE_WIDTH-1:0] value [2];
    value[0] = x_pole;
    value[1] = y_pole;
    for (int r = 0; r < 2; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(r), 2'b00};
      pwdata  <= {(APB_DATA_WIDTH - POLE_WIDTH)'($urandom), value[r]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      pole_q[r] = value[r];
      pole_writes++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [FIELD_WIDTH-1:0] want,
                             input logic [FIELD_WIDTH-1:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endtask

  // Receive side: check each estimate word against the oldest logged one, and
  // stall ready in random bursts outside the steady stretch.
  always @(posedge clk) begin
    if (rst) begin
      estimate_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (estimate_ch.valid && estimate_ch.ready) begin
        estimates_seen++;
        if (pending_estimates.size() == 0) begin
          fail_count++;
          $error("estimate word with nothing pending: %h %h %h",
                 estimate_ch.vel_x, estimate_ch.vel_y, estimate_ch.vel_z);
        end else begin
          check_field("vel_x", pending_estimates[0].vel_x, estimate_ch.vel_x);
          check_field("vel_y", pending_estimates[0].vel_y, estimate_ch.vel_y);
          check_field("vel_z", pending_estimates[0].vel_z, estimate_ch.vel_z);
          void'(pending_estimates.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        estimate_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        estimate_ch.ready <= 1'b0;
      end else begin
        estimate_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    sample_t s;
    int      kind;
    int      span;

    psel                      <= 1'b0;
    penable                   <= 1'b0;
    pwrite                    <= 1'b0;
    paddr                     <= '0;
    pwdata                    <= '0;
    sample_ch.valid           <= 1'b0;
    sample_ch.pos_x           <= '0;
    sample_ch.pos_y           <= '0;
    sample_ch.sample_interval <= '0;
    sample_ch.vz_in           <= '0;

    // Hold reset, then release it for good.
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed steps. The first ones run on the reset poles; change a pole
    // only once the block has gone quiet.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].x_pole != pole_q[0] || directed_rows[i].y_pole != pole_q[1]) begin
        drain();
        set_poles(directed_rows[i].x_pole, directed_rows[i].y_pole);
      end
      s.pos_x = directed_rows[i].pos_x;
      s.pos_y = directed_rows[i].pos_y;
      s.dt    = directed_rows[i].dt;
      s.vz    = directed_rows[i].vz;
      send_sample(s, directed_rows[i].known, directed_rows[i].want_x,
                  directed_rows[i].want_y);
    end

    // Random phases, each under fresh poles written while idle. Most words
    // follow a smooth track at a tracker-like interval; the rest are raw noise,
    // full-scale jumps and zero intervals. The last phase runs without idling.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 4))
        0:       set_poles(16'h0000, 16'hFFFF);
        1:       set_poles(16'hFFFF, 16'($urandom_range(1, 16'h00FF)));
        2:       set_poles(POLE_RESET, 16'($urandom));
        default: set_poles(16'($urandom), 16'($urandom));
      endcase
      steady = (phase == RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(4, 24);
        s.vz = $urandom;
        case (kind)
          7: begin
            s.pos_x = $urandom;
            s.pos_y = $urandom;
            s.dt    = 16'($urandom);
          end
          8: begin
            s.pos_x = extreme_pos[$urandom_range(0, 3)];
            s.pos_y = extreme_pos[$urandom_range(0, 3)];
            s.dt    = extreme_dt[$urandom_range(0, 3)];
          end
          default: begin
            s.pos_x = 32'(last_pos[0] + $urandom_range(0, 2 * span) - span);
            s.pos_y = 32'(last_pos[1] + $urandom_range(0, 2 * span) - span);
            s.dt    = (kind == 9) ? 16'h0000 : 16'($urandom_range(16'h0040, 16'h4000));
          end
        endcase
        send_sample(s, 1'b0, '0, '0);
      end
    end

    // Wait out the last estimates, then watch a little longer for strays.
    drain();
    repeat (POS_WIDTH + 20) @(posedge clk);

    $display("covered %0d sample words and %0d estimate words under %0d pole writes",
             samples_sent, estimates_seen, pole_writes);
    $display("saturation, zero pole, zero interval and full-scale steps included");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/bve_pkg.sv
rtl/bve_sample_if.sv
rtl/bve_estimate_if.sv
rtl/bve_axis.sv
rtl/bve_ctrl.sv
rtl/bilinear_velocity_estimator.sv
tb/bilinear_velocity_estimator_tb.sv
